@@ rtl/c2e_pkg.sv @@
// shared constants, types and the month table for the calendar to epoch block
// no dependencies
`default_nettype none

package c2e_pkg;

	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int EPOCH_W  = 32;

	// years past 1970, 0..135
	localparam int YOFS_W   = 8;
	// days of the month table plus the leap day, up to 335
	localparam int MDAYS_W  = 9;
	// total day count, up to about 49.7k
	localparam int DAYS_W   = 16;
	// seconds of the day, hour/minute/second at full field width
	localparam int TOD_W    = 17;

	localparam logic [YEAR_W-1:0]   YEAR_FIRST = 12'd1970;
	localparam logic [YEAR_W-1:0]   YEAR_LAST  = 12'd2105;
	// 2100 is the only century year in range that is not leap
	localparam logic [YOFS_W-1:0]   YOFS_2100  = 8'd130;
	localparam logic [YOFS_W-1:0]   YOFS_2101  = 8'd131;
	localparam logic [MONTH_W-1:0]  MONTH_JAN  = 4'd1;
	localparam logic [MONTH_W-1:0]  MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0]  MONTH_DEC  = 4'd12;
	localparam logic [DAY_W-1:0]    DAY_FIRST  = 5'd1;
	localparam logic [8:0]          DAYS_YEAR  = 9'd365;
	localparam logic [11:0]         SECS_HOUR  = 12'd3600;
	localparam logic [5:0]          SECS_MIN   = 6'd60;
	localparam logic [TOD_W-1:0]    SECS_DAY   = 17'd86400;
	localparam logic [EPOCH_W-1:0]  EXPIRY_RESET = 32'd1568431212;

	typedef struct packed {
		logic [DAYS_W-1:0] days;
		logic [TOD_W-1:0]  tod;
	} days_item_t;

	// days before the start of a month in a common year, index 0 is january
	function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] idx);
		logic [MDAYS_W-1:0] d;
		case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

@@ rtl/c2e_days.sv @@
// first two pipeline stages: field clamping, day count and seconds of the day
// depends on c2e_pkg
`default_nettype none

module c2e_days import c2e_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_en,
	input  wire logic [YEAR_W-1:0]   year,
	input  wire logic [MONTH_W-1:0]  month,
	input  wire logic [DAY_W-1:0]    day,
	input  wire logic [HOUR_W-1:0]   hour,
	input  wire logic [MINUTE_W-1:0] minute,
	input  wire logic [SECOND_W-1:0] second,
	input  wire logic                dn_en,
	output logic                     dn_valid,
	output days_item_t               dn_item
);

	logic                 valid_s1;
	logic [DAYS_W-1:0]    ydays_s1;
	logic [MDAYS_W-1:0]   mdays_s1;
	logic [DAY_W-1:0]     dm1_s1;
	logic [HOUR_W-1:0]    hour_s1;
	logic [MINUTE_W-1:0]  minute_s1;
	logic [SECOND_W-1:0]  second_s1;

	logic                 valid_s2;
	days_item_t           item_s2;

	logic                 en1;
	logic                 en2;
	logic [YEAR_W-1:0]    ycl;
	logic [YOFS_W-1:0]    yofs;
	logic [YOFS_W-1:0]    leaps;
	logic                 leap_now;
	logic [MONTH_W-1:0]   mcl;
	logic [DAY_W-1:0]     dcl;
	logic [MDAYS_W-1:0]   mdays;
	logic [DAYS_W-1:0]    ydays;

	// bubbles collapse: a stage moves when empty or when the next one moves
	assign en2   = !valid_s2 || dn_en;
	assign en1   = !valid_s1 || en2;
	assign in_en = en1;

	always_comb begin
		ycl = year;
		if (year < YEAR_FIRST) begin
			ycl = YEAR_FIRST;
		end
		if (year > YEAR_LAST) begin
			ycl = YEAR_LAST;
		end
		yofs = YOFS_W'(ycl - YEAR_FIRST);
		// leap years in 1970..year-1; 2100 dropped once we are past it
		leaps = YOFS_W'((YOFS_W'(yofs + 8'd1)) >> 2);
		if (yofs >= YOFS_2101) begin
			leaps = YOFS_W'(leaps - 8'd1);
		end
		leap_now = (yofs[1:0] == 2'd2) && (yofs != YOFS_2100);

		mcl = month;
		if (month < MONTH_JAN) begin
			mcl = MONTH_JAN;
		end
		if (month > MONTH_DEC) begin
			mcl = MONTH_DEC;
		end
		mdays = days_before_month(MONTH_W'(mcl - MONTH_JAN));
		if (mcl > MONTH_FEB && leap_now) begin
			mdays = MDAYS_W'(mdays + 9'd1);
		end

		dcl = (day < DAY_FIRST) ? DAY_FIRST : day;
		ydays = DAYS_W'(DAYS_W'(yofs) * DAYS_W'(DAYS_YEAR)) + DAYS_W'(leaps);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ydays_s1  <= ydays;
			mdays_s1  <= mdays;
			dm1_s1    <= DAY_W'(dcl - DAY_FIRST);
			hour_s1   <= hour;
			minute_s1 <= minute;
			second_s1 <= second;
		end
		if (en2) begin
			item_s2.days <= DAYS_W'(ydays_s1 + DAYS_W'(mdays_s1) + DAYS_W'(dm1_s1));
			item_s2.tod  <= TOD_W'(TOD_W'(hour_s1) * TOD_W'(SECS_HOUR))
				+ TOD_W'(TOD_W'(minute_s1) * TOD_W'(SECS_MIN))
				+ TOD_W'(second_s1);
		end
	end

	assign dn_valid = valid_s2;
	assign dn_item  = item_s2;

endmodule

`default_nettype wire

@@ rtl/c2e_secs.sv @@
// third pipeline stage: day count times 86400 plus seconds of the day
// depends on c2e_pkg
`default_nettype none

module c2e_secs import c2e_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               up_valid,
	input  wire days_item_t         up_item,
	output logic                    up_en,
	input  wire logic               dn_en,
	output logic                    dn_valid,
	output logic [EPOCH_W-1:0]      dn_secs
);

	logic               valid_s3;
	logic [EPOCH_W-1:0] secs_s3;
	logic               en3;
	logic [DAYS_W+TOD_W-1:0] prod;

	assign en3   = !valid_s3 || dn_en;
	assign up_en = en3;
	assign prod  = (DAYS_W+TOD_W)'(up_item.days) * (DAYS_W+TOD_W)'(SECS_DAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= up_valid;
		end
	end

	// sum wraps at 32 bits
	always_ff @(posedge clk) begin
		if (en3) begin
			secs_s3 <= EPOCH_W'(prod) + EPOCH_W'(up_item.tod);
		end
	end

	assign dn_valid = valid_s3;
	assign dn_secs  = secs_s3;

endmodule

`default_nettype wire

@@ rtl/calendar_to_epoch_expiry_check.sv @@
// top level: calendar time to epoch seconds with expiry compare
// depends on c2e_pkg, c2e_days, c2e_secs
`default_nettype none

// Converts one Gregorian calendar time per item into seconds since
// 1970-01-01 00:00:00 and flags whether that value is below the expiry
// register. Years are clamped into 1970..2105, month 0 reads as January,
// months above 12 as December, day 0 as day 1; days past the month end and
// oversize hour, minute or second fields simply add at their weight.
// The path is a four-stage pipeline: clamp and year/month day counts, day
// sum and seconds of the day, the multiply by 86400, then the expiry compare
// in the output register. One item is accepted every clock unless the
// pipeline is backed up; each item passes the stage registers in order.
// A stalled output only backs up the pipeline once every stage holds an
// item; empty stages keep filling meanwhile. The expiry register resets to
// 1568431212, is written through the cfg port (cfg_ready is always high) and
// must only be changed while no item is in flight.
module calendar_to_epoch_expiry_check import c2e_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,

	// config write channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [EPOCH_W-1:0]  cfg_data,

	// item input
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [YEAR_W-1:0]   year,
	input  wire logic [MONTH_W-1:0]  month,
	input  wire logic [DAY_W-1:0]    day,
	input  wire logic [HOUR_W-1:0]   hour,
	input  wire logic [MINUTE_W-1:0] minute,
	input  wire logic [SECOND_W-1:0] second,

	// result output
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [EPOCH_W-1:0]       epoch_seconds,
	output logic                     before_expiry
);

	logic               in_en;
	logic               days_valid;
	days_item_t         days_item;
	logic               secs_en;
	logic               secs_valid;
	logic [EPOCH_W-1:0] secs;
	logic               en4;

	logic [EPOCH_W-1:0] expiry_q;
	logic               valid_s4;
	logic [EPOCH_W-1:0] epoch_s4;
	logic               before_s4;

	// stages one and two: clamping, day count, seconds of the day
	c2e_days u_days (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_en    (in_en),
		.year     (year),
		.month    (month),
		.day      (day),
		.hour     (hour),
		.minute   (minute),
		.second   (second),
		.dn_en    (secs_en),
		.dn_valid (days_valid),
		.dn_item  (days_item)
	);

	// stage three: days to seconds
	c2e_secs u_secs (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (days_valid),
		.up_item  (days_item),
		.up_en    (secs_en),
		.dn_en    (en4),
		.dn_valid (secs_valid),
		.dn_secs  (secs)
	);

	// the config register is always free to take a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= EXPIRY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			expiry_q <= cfg_data;
		end
	end

	// stage four is the output register; it loads when empty or taken
	assign en4 = !valid_s4 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en4) begin
			valid_s4 <= secs_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			epoch_s4  <= secs;
			before_s4 <= (secs < expiry_q);
		end
	end

	assign in_stall      = !in_en;
	assign out_valid     = valid_s4;
	assign epoch_seconds = epoch_s4;
	assign before_expiry = before_s4;

endmodule

`default_nettype wire

@@ rtl/c2e_checker.sv @@
// port-level checks for the calendar to epoch block, bound to its top level
// depends on c2e_pkg and calendar_to_epoch_expiry_check
`default_nettype none

module c2e_checker import c2e_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [EPOCH_W-1:0]  epoch_seconds,
	input wire logic                before_expiry
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(epoch_seconds)
			&& $stable(before_expiry))
		else $error("held result changed");

	// input backs up only from a result waiting at a stalled output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// with the output empty, a new result comes from an item accepted earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 4))
		else $error("result without matching item");

endmodule

bind calendar_to_epoch_expiry_check c2e_checker u_c2e_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.epoch_seconds (epoch_seconds),
	.before_expiry (before_expiry)
);

`default_nettype wire

@@ test/tb_calendar_to_epoch_expiry_check.sv @@
`timescale 1ns / 100ps
// testbench for calendar_to_epoch_expiry_check: calendar corner rows, then random dates
// under several expiry settings, each checked against a typed answer or an in-bench predictor
// depends on c2e_pkg and the calendar_to_epoch_expiry_check rtl

module tb_calendar_to_epoch_expiry_check;
	import c2e_pkg::*;

	// one calendar time as it goes onto the input ports
	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} cal_time_t;

	// what the block should report for one calendar time
	typedef struct packed {
		logic [EPOCH_W-1:0] secs;
		logic               early;
	} epoch_result_t;

	// a row of the corner table; typed rows carry a hand-worked answer
	typedef struct {
		cal_time_t     when;
		bit            typed;
		epoch_result_t result;
	} corner_row_t;

	// leap days that fall in years 1..1969, taken off every day count
	localparam int unsigned LEAPS_BY_1969    = 1969 / 4 - 1969 / 100 + 1969 / 400;
	localparam int unsigned PHASES           = 7;
	localparam int unsigned ITEMS_PER_PHASE  = 245;
	localparam int unsigned CALM_RUN         = 50;
	// four pipeline stages plus margin
	localparam int unsigned DRAIN_CYCLES     = 8;

	// days before each month in a common year, and the month lengths
	int unsigned month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	int unsigned month_len [12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	// years where the leap rule or the clamp has something to say
	int unsigned corner_years [6] = '{1970, 1972, 2000, 2099, 2100, 2105};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [EPOCH_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [DAY_W-1:0]    day;
	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;
	logic [SECOND_W-1:0] second;
	logic                out_valid;
	logic                out_stall;
	logic [EPOCH_W-1:0]  epoch_seconds;
	logic                before_expiry;

	// our own copy of the expiry register, updated on each accepted write
	logic [EPOCH_W-1:0]  expiry_model;
	// results still owed by the block, oldest first
	epoch_result_t       epoch_due [$];
	corner_row_t         corner_rows [$];

	// when set, that side stops idling for a while
	bit                  tx_calm;
	bit                  rx_calm;

	int unsigned         errors;
	int unsigned         items_sent;
	int unsigned         results_checked;
	int unsigned         early_seen;
	int unsigned         late_seen;
	int unsigned         settings_used;

	calendar_to_epoch_expiry_check DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.epoch_seconds (epoch_seconds),
		.before_expiry (before_expiry)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit is_leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// epoch seconds of a calendar time, with the same clamps as the block:
	// year into 1970..2105, month 0 as january, month past 12 as december,
	// day 0 as day 1; overlong day, hour, minute, second just add on
	function automatic epoch_result_t calendar_to_seconds(input cal_time_t t,
			input logic [EPOCH_W-1:0] limit);
		int unsigned     y;
		int unsigned     m;
		int unsigned     d;
		int unsigned     days;
		longint unsigned total;
		epoch_result_t   r;
		y = t.year;
		m = t.month;
		d = t.day;
		if (y < YEAR_FIRST) y = YEAR_FIRST;
		if (y > YEAR_LAST) y = YEAR_LAST;
		if (m == 0) m = 1;
		if (m > 12) m = 12;
		if (d == 0) d = 1;
		// whole years, then leap days of the years already passed
		days = (y - YEAR_FIRST) * 365 + ((y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400)
			- LEAPS_BY_1969;
		days += month_start[m - 1];
		// leap day only counts once february is behind us
		if (m > 2 && is_leap_year(y)) days++;
		days += d - 1;
		total = longint'(days) * 86400 + longint'(t.hour) * 3600
			+ longint'(t.minute) * 60 + longint'(t.second);
		r.secs  = total[EPOCH_W-1:0];
		r.early = (r.secs < limit);
		return r;
	endfunction

	// mostly real dates, some with one field pushed out of range, some raw bits
	function automatic cal_time_t random_time();
		cal_time_t   t;
		logic [63:0] noise;
		int unsigned kind;
		int unsigned last;
		kind  = $urandom_range(0, 99);
		noise = {$urandom, $urandom};
		if (kind < 12) begin
			t = noise[37:0];
		end else begin
			if ($urandom_range(0, 7) == 0)
				t.year = YEAR_W'(corner_years[$urandom_range(0, 5)]);
			else
				t.year = YEAR_W'($urandom_range(1970, 2105));
			t.month  = MONTH_W'($urandom_range(1, 12));
			last     = month_len[t.month - 1]
				+ ((t.month == MONTH_FEB && is_leap_year(t.year)) ? 1 : 0);
			t.day    = DAY_W'($urandom_range(1, last));
			t.hour   = HOUR_W'($urandom_range(0, 23));
			t.minute = MINUTE_W'($urandom_range(0, 59));
			t.second = SECOND_W'($urandom_range(0, 59));
			// break one field of a real date
			if (kind < 26) begin
				case ($urandom_range(0, 5))
					0: t.year = $urandom_range(0, 1) ? YEAR_W'($urandom_range(0, 1969))
						: YEAR_W'($urandom_range(2106, 4095));
					1: t.month = $urandom_range(0, 1) ? MONTH_JAN - MONTH_JAN
						: MONTH_W'($urandom_range(13, 15));
					2: t.day = $urandom_range(0, 1) ? DAY_W'(0) : DAY_W'($urandom_range(29, 31));
					3: t.hour = HOUR_W'($urandom_range(24, 31));
					4: t.minute = MINUTE_W'($urandom_range(60, 63));
					default: t.second = SECOND_W'($urandom_range(60, 63));
				endcase
			end
		end
		return t;
	endfunction

	function automatic void add_row(input int unsigned y, input int unsigned mo,
			input int unsigned d, input int unsigned h, input int unsigned mi,
			input int unsigned s, input bit typed, input logic [EPOCH_W-1:0] secs,
			input bit early);
		corner_row_t row;
		row.when.year    = YEAR_W'(y);
		row.when.month   = MONTH_W'(mo);
		row.when.day     = DAY_W'(d);
		row.when.hour    = HOUR_W'(h);
		row.when.minute  = MINUTE_W'(mi);
		row.when.second  = SECOND_W'(s);
		row.typed        = typed;
		row.result.secs  = secs;
		row.result.early = early;
		corner_rows.push_back(row);
	endfunction

	// one calendar time onto the input; valid stays up across back-to-back items
	task automatic send_time(input cal_time_t t, input bit typed, input epoch_result_t given);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		year     <= t.year;
		month    <= t.month;
		day      <= t.day;
		hour     <= t.hour;
		minute   <= t.minute;
		second   <= t.second;
		do @(posedge clk); while (in_stall);
		// the expectation is taken against the register value in force now
		epoch_due.push_back(typed ? given : calendar_to_seconds(t, expiry_model));
		items_sent++;
	endtask

	// stop sending and let everything in flight come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (epoch_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// only called with the pipeline empty
	task automatic write_expiry(input logic [EPOCH_W-1:0] limit);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= limit;
		do @(posedge clk); while (!cfg_ready);
		expiry_model = limit;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stall before each result, with calm stretches
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = rx_calm ? 0 : $urandom_range(0, 9);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		epoch_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (epoch_due.size() == 0) begin
				$display("%0t ns: result with none expected, epoch_seconds %0d before_expiry %0b",
					$time, epoch_seconds, before_expiry);
				errors++;
			end else begin
				want = epoch_due.pop_front();
				results_checked++;
				if (before_expiry) early_seen++;
				else late_seen++;
				if (epoch_seconds !== want.secs) begin
					$display("%0t ns: epoch_seconds mismatch, expected %0d, actual %0d",
						$time, want.secs, epoch_seconds);
					errors++;
				end
				if (before_expiry !== want.early) begin
					$display("%0t ns: before_expiry mismatch, expected %0b, actual %0b",
						$time, want.early, before_expiry);
					errors++;
				end
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#1_000_000;
		$display("%0t ns: timeout with %0d results outstanding", $time, epoch_due.size());
		$display("tb_calendar_to_epoch_expiry_check: FAIL");
		$finish;
	end

	initial begin
		int unsigned        phase;
		int unsigned        n;
		logic [EPOCH_W-1:0] limit;
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		year            = '0;
		month           = '0;
		day             = '0;
		hour            = '0;
		minute          = '0;
		second          = '0;
		tx_calm         = 1'b0;
		rx_calm         = 1'b0;
		errors          = 0;
		items_sent      = 0;
		results_checked = 0;
		early_seen      = 0;
		late_seen       = 0;
		settings_used   = 0;
		expiry_model    = EXPIRY_RESET;

		// typed rows: the epoch itself, the low clamp, the first day and year boundaries,
		// the expiry reset value and one second below it, and the top of the range
		add_row(1970, 1, 1, 0, 0, 0, 1, 32'd0, 1);
		add_row(0, 0, 0, 0, 0, 0, 1, 32'd0, 1);
		add_row(1970, 1, 1, 23, 59, 59, 1, 32'd86399, 1);
		add_row(1970, 1, 2, 0, 0, 0, 1, 32'd86400, 1);
		add_row(1971, 1, 1, 0, 0, 0, 1, 32'd31536000, 1);
		add_row(2019, 9, 14, 3, 20, 12, 1, 32'd1568431212, 0);
		add_row(2019, 9, 14, 3, 20, 11, 1, 32'd1568431211, 1);
		add_row(2105, 12, 31, 23, 59, 59, 1, 32'd4291747199, 0);
		// every field at its all-ones value: high clamps plus overlong time of day
		add_row(4095, 15, 31, 31, 63, 63, 1, 32'd4291776243, 0);
		// leap day handling around february, including the skipped century
		add_row(1972, 2, 29, 12, 0, 0, 0, '0, 0);
		add_row(1972, 3, 1, 0, 0, 0, 0, '0, 0);
		add_row(2000, 2, 29, 23, 59, 59, 0, '0, 0);
		add_row(2000, 3, 1, 0, 0, 0, 0, '0, 0);
		add_row(2100, 2, 28, 23, 59, 59, 0, '0, 0);
		add_row(2100, 3, 1, 0, 0, 0, 0, '0, 0);
		add_row(2104, 12, 31, 12, 30, 30, 0, '0, 0);
		// clamps on year and month, day zero
		add_row(1969, 6, 15, 8, 0, 0, 0, '0, 0);
		add_row(2106, 1, 1, 0, 0, 0, 0, '0, 0);
		add_row(2010, 0, 10, 1, 2, 3, 0, '0, 0);
		add_row(2010, 13, 5, 4, 5, 6, 0, '0, 0);
		add_row(2050, 7, 0, 9, 9, 9, 0, '0, 0);
		// days past the month end roll on into the next month
		add_row(2023, 2, 31, 0, 0, 0, 0, '0, 0);
		add_row(2023, 4, 31, 8, 30, 0, 0, '0, 0);
		// oversize hour, minute and second add at their weight
		add_row(2000, 1, 1, 31, 63, 63, 0, '0, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corner table at the reset value of the expiry register
		foreach (corner_rows[i])
			send_time(corner_rows[i].when, corner_rows[i].typed, corner_rows[i].result);

		// random phases, each under its own expiry setting; the register is only
		// rewritten with the pipeline drained, which also gives the sender full stops
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				drain();
				case (phase)
					1: limit = '0;
					2: limit = '1;
					3: limit = 32'h8000_0000;
					6: limit = $urandom;
					// somewhere among the dates we generate, so both flag values show
					default: limit = $urandom_range(0, 32'hFFCE_0000);
				endcase
				write_expiry(limit);
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % CALM_RUN == 0) begin
					tx_calm = ($urandom_range(0, 3) == 0);
					rx_calm = ($urandom_range(0, 3) == 0);
				end
				send_time(random_time(), 1'b0, '0);
			end
		end
		drain();

		$display("%0d calendar times sent (%0d corner rows), %0d results checked",
			items_sent, corner_rows.size(), results_checked);
		$display("expiry register written %0d times; flag seen high %0d, low %0d",
			settings_used, early_seen, late_seen);
		if (errors == 0) begin
			$display("tb_calendar_to_epoch_expiry_check: PASS");
		end else begin
			$display("tb_calendar_to_epoch_expiry_check: FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/c2e_pkg.sv
rtl/c2e_days.sv
rtl/c2e_secs.sv
rtl/calendar_to_epoch_expiry_check.sv
rtl/c2e_checker.sv
test/tb_calendar_to_epoch_expiry_check.sv
